// ===== sv/key_debounce_long_press_core_assert.svh =====
// Assertion macros shared by the key debounce RTL.
`ifndef KEY_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH
`define KEY_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define KDLP_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that a trigger is followed by a condition on the next edge.
`define KDLP_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== sv/kdlp_pkg.sv =====
// Types and constants of the key debounce and long-press block.
package kdlp_pkg;

	localparam int KEY_ID_W = 4;
	localparam int RAW_W    = 16;
	localparam int TIME_W   = 32;
	localparam int CNT_W    = 8;
	localparam int LONG_W   = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS  = 2'd1;

	localparam logic [CNT_W-1:0]  DEBOUNCE_RST = 8'd2;
	localparam logic [LONG_W-1:0] LONG_MS_RST  = 16'd1000;
	localparam logic [CNT_W-1:0]  CNT_MAX      = 8'hFF;

	localparam logic EV_SHORT = 1'b0;
	localparam logic EV_LONG  = 1'b1;

	// Per-key state word kept in the state memory.
	typedef struct packed {
		logic [CNT_W-1:0]  press_cnt;
		logic [CNT_W-1:0]  rel_cnt;
		logic              down;
		logic              long_fired;
		logic [TIME_W-1:0] start_ms;
	} kdlp_entry_t;

	// One event request on its way to the output.
	typedef struct packed {
		logic [KEY_ID_W-1:0] key_id;
		logic                kind;
		logic                last;
	} kdlp_evt_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

// ===== sv/kdlp_if.sv =====
// Scan and event channel interfaces of the key debounce block.
interface kdlp_scan_if import kdlp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [RAW_W-1:0]  raw_keys;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, output raw_keys, output now_ms, input ready);
	modport sink   (input valid, input raw_keys, input now_ms, output ready);
endinterface

interface kdlp_event_if import kdlp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [KEY_ID_W-1:0] key_id;
	logic                event_kind;
	logic                last_event;

	modport source (output valid, output key_id, output event_kind, output last_event,
		input ready);
	modport sink   (input valid, input key_id, input event_kind, input last_event,
		output ready);
endinterface

// ===== sv/key_debounce_long_press_core.sv =====
// Top level of the key debounce and short/long press detector.
//
// Usage: each request on the scan channel is one scan tick: raw_keys holds the
// raw level of every key (1 = pressed), now_ms the free-running millisecond time.
// Keys are processed one per cycle, unless the event path stalls, from a per-key
// state memory with a read port and a write port; scans may follow back to back.
// Each short or long press comes out as one request on the event channel, in
// key order; the final event of a scan carries last_event. A scan may give none.
// An event passes from the modify stage through the holding stage to the output
// register; it waits in the holding stage until the next event of its scan
// arrives or the scan's last key has passed the modify stage, which fixes last_event.
// The registers debounce_count (index 0) and long_press_ms (index 1) are written
// through cfg_wr_en, cfg_index and cfg_data; the user must write them only while the
// block is idle; the block does not enforce it. Reset clears all key state (through
// per-key valid bits, no clearing pass) and loads the register defaults. When the
// event receiver stalls, a holding stage absorbs one event; further events stall
// processing and the scan input.
module key_debounce_long_press_core
	import kdlp_pkg::*;
#(
	parameter int NUM_KEYS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	kdlp_scan_if.sink            scan,
	kdlp_event_if.source         evt
);

	`include "key_debounce_long_press_core_assert.svh"

	localparam int KIDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam logic [KEY_ID_W-1:0] LAST_KEY = KEY_ID_W'(NUM_KEYS - 1);

	// Configuration registers
	logic [CNT_W-1:0]  debounce_q;
	logic [LONG_W-1:0] long_ms_q;

	// Scan sequencer
	logic              scan_active_q;
	logic [KEY_ID_W-1:0] key_q;
	logic [RAW_W-1:0]  raw_q;
	logic [TIME_W-1:0] now_q;

	// Modify stage
	logic                s1_valid_q;
	logic [KEY_ID_W-1:0] key_s1;
	logic                level_s1;
	logic [TIME_W-1:0]   now_s1;
	logic                last_s1;
	kdlp_entry_t         rd_data_s1;
	logic                rd_vld_s1;
	logic                fwd_s1;
	kdlp_entry_t         fwd_data_s1;

	// State memory and valid bits
	kdlp_entry_t         mem [NUM_KEYS];
	logic [NUM_KEYS-1:0] ent_vld_q;

	// Event holding and output stages
	logic      pend_valid_q;
	kdlp_evt_t pend_q;
	logic      out_valid_q;
	kdlp_evt_t out_q;

	logic              issue;
	logic              key_last;
	logic              stall;
	logic              s1_adv;
	logic              out_free;
	logic              pend_move;
	logic              has_evt;
	logic              evt_kind;
	logic [KIDX_W-1:0] rd_addr;
	logic [KIDX_W-1:0] wr_addr;
	kdlp_entry_t       cur;
	kdlp_entry_t       nxt;
	logic [TIME_W-1:0] held;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			long_ms_q  <= LONG_MS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_DEBOUNCE: debounce_q <= cfg_data[CNT_W-1:0];
				CFG_LONG_MS:  long_ms_q  <= cfg_data[LONG_W-1:0];
				default: ;
			endcase
		end
	end

	// Pick the current state word: forwarded, stored or reset value
	always_comb begin
		if (fwd_s1) begin
			cur = fwd_data_s1;
		end else if (rd_vld_s1) begin
			cur = rd_data_s1;
		end else begin
			cur = '0;
		end
	end

	// Update one key's state and decide on an event
	always_comb begin
		nxt      = cur;
		has_evt  = 1'b0;
		evt_kind = EV_SHORT;
		held     = now_s1 - cur.start_ms;
		if (level_s1) begin
			nxt.rel_cnt = '0;
			if (!cur.down) begin
				nxt.press_cnt = sat_inc(cur.press_cnt);
				if (nxt.press_cnt >= debounce_q) begin
					nxt.down       = 1'b1;
					nxt.long_fired = 1'b0;
					nxt.start_ms   = now_s1;
				end
			end else if (!cur.long_fired) begin
				if (held >= {{(TIME_W-LONG_W){1'b0}}, long_ms_q}) begin
					nxt.long_fired = 1'b1;
					has_evt        = 1'b1;
					evt_kind       = EV_LONG;
				end
			end
		end else begin
			nxt.press_cnt = '0;
			if (cur.down) begin
				nxt.rel_cnt = sat_inc(cur.rel_cnt);
				if (nxt.rel_cnt >= debounce_q) begin
					has_evt  = !cur.long_fired;
					evt_kind = EV_SHORT;
					nxt.down = 1'b0;
				end
			end
		end
	end

	// Flow control between the stages
	assign out_free  = !out_valid_q || evt.ready;
	assign pend_move = pend_valid_q && out_free && (pend_q.last || (s1_valid_q && has_evt));
	assign stall     = s1_valid_q && has_evt && pend_valid_q && !pend_move;
	assign s1_adv    = s1_valid_q && !stall;
	assign issue     = scan_active_q && !stall;
	assign key_last  = (key_q == LAST_KEY);
	assign rd_addr   = key_q[KIDX_W-1:0];
	assign wr_addr   = key_s1[KIDX_W-1:0];
	assign scan.ready = !scan_active_q || (issue && key_last);

	// Accept scans and step through the keys
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_active_q <= 1'b0;
			key_q         <= '0;
		end else if (scan.valid && scan.ready) begin
			scan_active_q <= 1'b1;
			key_q         <= '0;
		end else if (issue) begin
			key_q <= key_q + 1'b1;
			if (key_last) begin
				scan_active_q <= 1'b0;
			end
		end
	end

	// Hold the scan payload
	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			raw_q <= scan.raw_keys;
			now_q <= scan.now_ms;
		end
	end

	// Read and write the state memory
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (s1_adv) begin
			mem[wr_addr] <= nxt;
		end
	end

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (s1_adv) begin
			ent_vld_q[wr_addr] <= 1'b1;
		end
	end

	// Load the modify stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
			rd_vld_s1  <= 1'b0;
		end else if (issue) begin
			s1_valid_q <= 1'b1;
			fwd_s1     <= s1_adv && (wr_addr == rd_addr);
			rd_vld_s1  <= ent_vld_q[rd_addr];
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			key_s1      <= key_q;
			level_s1    <= raw_q[key_q];
			now_s1      <= now_q;
			last_s1     <= key_last;
			fwd_data_s1 <= nxt;
		end
	end

	// Hold the latest event until its successor or the scan end is known
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
		end else if (s1_adv && has_evt) begin
			pend_valid_q  <= 1'b1;
			pend_q.key_id <= key_s1;
			pend_q.kind   <= evt_kind;
			pend_q.last   <= last_s1;
		end else if (pend_move) begin
			pend_valid_q <= 1'b0;
		end else if (s1_adv && last_s1 && pend_valid_q) begin
			pend_q.last <= 1'b1;
		end
	end

	// Drive the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_move) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_move) begin
			out_q <= pend_q;
		end
	end

	assign evt.valid      = out_valid_q;
	assign evt.key_id     = out_q.key_id;
	assign evt.event_kind = out_q.kind;
	assign evt.last_event = out_q.last;

	// Checks
	`KDLP_ASSERT(a_ready_mid_scan, !(scan.ready && scan_active_q) || (issue && key_last),
		"scan accepted before the current scan finished issuing")
	`KDLP_ASSERT_NEXT(a_fwd_same_key, issue && s1_adv && (wr_addr == rd_addr), fwd_s1,
		"read of a key being written did not forward")
	`KDLP_ASSERT(a_stall_blocks_write, !stall || !s1_adv,
		"modify stage wrote back while stalled")
	`KDLP_ASSERT_NEXT(a_pend_leaves, pend_move, out_valid_q,
		"held event moved but output register stayed empty")

endmodule
